// ===== rtl/core/lcb_pkg.sv =====
// ----------------------------------------------------------------------------
// lcb_pkg
// Shared types and constants of the least-connections balancer.
// ----------------------------------------------------------------------------
package lcb_pkg;

  localparam logic [1:0] CFG_BASE_ADDR = 2'd0;
  localparam logic [1:0] CFG_SRV_COUNT = 2'd1;
  localparam logic [1:0] CFG_SVC_PORT  = 2'd2;

  localparam logic [31:0] RST_BASE_ADDR = 32'hC0A8_0102;
  localparam logic [4:0]  RST_SRV_COUNT = 5'd11;
  localparam logic [15:0] RST_SVC_PORT  = 16'd80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_HIT,
    ST_MIN,
    ST_MISS
  } state_e;

  typedef enum logic [1:0] {
    FIN_PASS,
    FIN_END,
    FIN_HIT,
    FIN_MISS
  } fin_e;

  typedef struct packed {
    logic take;
    logic scan_start;
    logic scan_step;
    logic min_start;
    logic min_step;
    logic finish;
    fin_e kind;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic op_end;
    logic outside;
    logic hit;
    logic scan_miss;
    logic min_done;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/core/lcb_in_if.sv =====
// ----------------------------------------------------------------------------
// lcb_in_if
// Input channel: packet header or connection-end item.
// ----------------------------------------------------------------------------
interface lcb_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        from_outside;
  logic        is_tcp;
  logic [31:0] client_ip;
  logic [15:0] client_port;
  logic [15:0] dest_port;
  logic [3:0]  end_server;

  modport source (output valid, operation, from_outside, is_tcp, client_ip,
                  client_port, dest_port, end_server, input ready);
  modport sink (input valid, operation, from_outside, is_tcp, client_ip,
                client_port, dest_port, end_server, output ready);
endinterface

// ===== rtl/core/lcb_out_if.sv =====
// ----------------------------------------------------------------------------
// lcb_out_if
// Output channel: one forwarding decision per item.
// ----------------------------------------------------------------------------
interface lcb_out_if;
  logic        valid;
  logic        ready;
  logic        forwarded;
  logic [3:0]  chosen_server;
  logic [31:0] server_addr;
  logic [15:0] new_dest_port;
  logic        flow_hit;
  logic [15:0] chosen_count;

  modport source (output valid, forwarded, chosen_server, server_addr,
                  new_dest_port, flow_hit, chosen_count, input ready);
  modport sink (input valid, forwarded, chosen_server, server_addr,
                new_dest_port, flow_hit, chosen_count, output ready);
endinterface

// ===== rtl/core/lcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcb_ctrl
// Sequencer: dispatch, flow-table walk, least-count search, finish.
// ----------------------------------------------------------------------------
module lcb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lcb_pkg::sts_t sts_i,
  output lcb_pkg::cmd_t cmd_o
);

  lcb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.kind       = lcb_pkg::FIN_PASS;
    case (state_q)
      lcb_pkg::ST_IDLE: begin
        cmd_o.take = 1'b1;
        if (sts_i.in_valid) state_d = lcb_pkg::ST_DISPATCH;
      end
      lcb_pkg::ST_DISPATCH: begin
        if (sts_i.op_end || !sts_i.outside) begin
          cmd_o.kind = sts_i.op_end ? lcb_pkg::FIN_END : lcb_pkg::FIN_PASS;
          if (!sts_i.out_busy) begin
            cmd_o.finish = 1'b1;
            state_d      = lcb_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = lcb_pkg::ST_SCAN;
        end
      end
      lcb_pkg::ST_SCAN: begin
        if (sts_i.hit) begin
          state_d = lcb_pkg::ST_HIT;
        end else if (sts_i.scan_miss) begin
          cmd_o.min_start = 1'b1;
          state_d         = lcb_pkg::ST_MIN;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      lcb_pkg::ST_HIT: begin
        cmd_o.kind = lcb_pkg::FIN_HIT;
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = lcb_pkg::ST_IDLE;
        end
      end
      lcb_pkg::ST_MIN: begin
        if (sts_i.min_done) begin
          state_d = lcb_pkg::ST_MISS;
        end else begin
          cmd_o.min_step = 1'b1;
        end
      end
      lcb_pkg::ST_MISS: begin
        cmd_o.kind = lcb_pkg::FIN_MISS;
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = lcb_pkg::ST_IDLE;
        end
      end
      default: state_d = lcb_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/lcb_dp.sv =====
// ----------------------------------------------------------------------------
// lcb_dp
// Datapath: config registers, connection counts, flow ring and result.
// ----------------------------------------------------------------------------
module lcb_dp #(
  parameter int MAX_SERVERS  = 16,
  parameter int FLOW_ENTRIES = 64,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i,
  input  lcb_pkg::cmd_t cmd_i,
  output lcb_pkg::sts_t sts_o,
  lcb_in_if.sink        in_i,
  lcb_out_if.source     out_o
);

  localparam int SW  = $clog2(MAX_SERVERS);
  localparam int NW  = $clog2(MAX_SERVERS + 1);
  localparam int FW  = $clog2(FLOW_ENTRIES);
  localparam int FCW = $clog2(FLOW_ENTRIES + 1);

  typedef struct packed {
    logic [31:0]   addr;
    logic [15:0]   port;
    logic [SW-1:0] srv;
  } flow_t;

  logic [31:0] base_q;
  logic [4:0]  scount_q;
  logic [15:0] sport_q;

  logic        op_q, outside_q, tcp_q;
  logic [31:0] cip_q;
  logic [15:0] cport_q, dport_q;
  logic [3:0]  endsrv_q;

  logic [COUNT_WIDTH-1:0] cnt_q [MAX_SERVERS];
  flow_t                  flow_mem [FLOW_ENTRIES];

  logic [FW-1:0]  wp_q, rd_ptr_q;
  logic [FCW-1:0] fill_q, rd_cnt_q;
  logic           cmp_vld_q;
  flow_t          ent_q;

  logic [NW-1:0]          k_q;
  logic [SW-1:0]          best_q;
  logic [COUNT_WIDTH-1:0] bval_q;
  logic                   first_q;

  logic [NW-1:0]          n_use;
  logic [31:0]            end32;
  logic                   end_ok;
  logic [SW-1:0]          rd_idx;
  logic [COUNT_WIDTH-1:0] cnt_rd, cnt_inc, cnt_dec;
  logic [SW-1:0]          res_srv;
  logic [31:0]            srv32;
  logic                   take;

  assign take  = in_i.valid && in_i.ready;
  assign in_i.ready = cmd_i.take;

  always_comb begin
    if (scount_q == 5'd0) begin
      n_use = NW'(1);
    end else if (32'(scount_q) > 32'(MAX_SERVERS)) begin
      n_use = NW'(MAX_SERVERS);
    end else begin
      n_use = NW'(scount_q);
    end
  end

  assign end32  = 32'(endsrv_q);
  assign end_ok = end32 < 32'(n_use);

  always_comb begin
    case (cmd_i.kind)
      lcb_pkg::FIN_END:  rd_idx = end32[SW-1:0];
      lcb_pkg::FIN_HIT:  rd_idx = ent_q.srv;
      lcb_pkg::FIN_MISS: rd_idx = best_q;
      default:           rd_idx = '0;
    endcase
    if (cmd_i.min_step) rd_idx = k_q[SW-1:0];
  end

  assign cnt_rd  = cnt_q[rd_idx];
  assign cnt_inc = (cnt_rd != '1) ? cnt_rd + 1'b1 : cnt_rd;
  assign cnt_dec = (cnt_rd != '0) ? cnt_rd - 1'b1 : cnt_rd;

  assign res_srv = (cmd_i.kind == lcb_pkg::FIN_HIT) ? ent_q.srv : best_q;
  assign srv32   = 32'(res_srv);

  assign sts_o.in_valid  = in_i.valid;
  assign sts_o.op_end    = op_q;
  assign sts_o.outside   = outside_q;
  assign sts_o.hit       = cmp_vld_q && (ent_q.addr == cip_q) && (ent_q.port == cport_q);
  assign sts_o.scan_miss = !cmp_vld_q && (rd_cnt_q == fill_q);
  assign sts_o.min_done  = (k_q == n_use);
  assign sts_o.out_busy  = out_o.valid && !out_o.ready;

  // Configuration and item capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= lcb_pkg::RST_BASE_ADDR;
      scount_q <= lcb_pkg::RST_SRV_COUNT;
      sport_q  <= lcb_pkg::RST_SVC_PORT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcb_pkg::CFG_BASE_ADDR: base_q   <= cfg_wdata_i;
        lcb_pkg::CFG_SRV_COUNT: scount_q <= cfg_wdata_i[4:0];
        lcb_pkg::CFG_SVC_PORT:  sport_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q      <= in_i.operation;
      outside_q <= in_i.from_outside;
      tcp_q     <= in_i.is_tcp;
      cip_q     <= in_i.client_ip;
      cport_q   <= in_i.client_port;
      dport_q   <= in_i.dest_port;
      endsrv_q  <= in_i.end_server;
    end
  end

  // Flow ring storage, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && cmd_i.kind == lcb_pkg::FIN_MISS && tcp_q) begin
      flow_mem[wp_q] <= '{addr: cip_q, port: cport_q, srv: best_q};
    end
    if (cmd_i.scan_step && rd_cnt_q != fill_q) begin
      ent_q <= flow_mem[rd_ptr_q];
    end
  end

  // Walk newest to oldest; entries past the fill count were never written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      wp_q      <= '0;
      fill_q    <= '0;
    end else begin
      if (cmd_i.scan_start) begin
        rd_ptr_q  <= (wp_q == '0) ? FW'(FLOW_ENTRIES - 1) : wp_q - 1'b1;
        rd_cnt_q  <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (rd_cnt_q != fill_q) begin
          rd_ptr_q  <= (rd_ptr_q == '0) ? FW'(FLOW_ENTRIES - 1) : rd_ptr_q - 1'b1;
          rd_cnt_q  <= rd_cnt_q + 1'b1;
          cmp_vld_q <= 1'b1;
        end else begin
          cmp_vld_q <= 1'b0;
        end
      end else if (cmd_i.finish) begin
        cmp_vld_q <= 1'b0;
      end
      if (cmd_i.finish && cmd_i.kind == lcb_pkg::FIN_MISS && tcp_q) begin
        wp_q <= (wp_q == FW'(FLOW_ENTRIES - 1)) ? '0 : wp_q + 1'b1;
        if (fill_q != FCW'(FLOW_ENTRIES)) fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Least-count search, one server a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      first_q <= 1'b0;
    end else if (cmd_i.min_start) begin
      k_q     <= '0;
      first_q <= 1'b1;
    end else if (cmd_i.min_step) begin
      k_q     <= k_q + 1'b1;
      first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.min_step && (first_q || cnt_rd < bval_q)) begin
      best_q <= k_q[SW-1:0];
      bval_q <= cnt_rd;
    end
  end

  // Counts and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SERVERS; i++) cnt_q[i] <= '0;
      out_o.valid <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        out_o.valid <= 1'b1;
        if (cmd_i.kind == lcb_pkg::FIN_END && end_ok) cnt_q[rd_idx] <= cnt_dec;
        if (cmd_i.kind == lcb_pkg::FIN_MISS) cnt_q[rd_idx] <= cnt_inc;
      end else if (out_o.ready) begin
        out_o.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      case (cmd_i.kind)
        lcb_pkg::FIN_END: begin
          out_o.forwarded     <= 1'b0;
          out_o.chosen_server <= endsrv_q;
          out_o.server_addr   <= '0;
          out_o.new_dest_port <= '0;
          out_o.flow_hit      <= 1'b0;
          out_o.chosen_count  <= end_ok ? 16'(32'(cnt_dec)) : '0;
        end
        lcb_pkg::FIN_HIT: begin
          out_o.forwarded     <= 1'b1;
          out_o.chosen_server <= srv32[3:0];
          out_o.server_addr   <= base_q + srv32;
          out_o.new_dest_port <= sport_q;
          out_o.flow_hit      <= 1'b1;
          out_o.chosen_count  <= 16'(32'(cnt_rd));
        end
        lcb_pkg::FIN_MISS: begin
          out_o.forwarded     <= 1'b1;
          out_o.chosen_server <= srv32[3:0];
          out_o.server_addr   <= base_q + srv32;
          out_o.new_dest_port <= dport_q;
          out_o.flow_hit      <= 1'b0;
          out_o.chosen_count  <= 16'(32'(cnt_inc));
        end
        default: begin
          out_o.forwarded     <= 1'b0;
          out_o.chosen_server <= '0;
          out_o.server_addr   <= '0;
          out_o.new_dest_port <= dport_q;
          out_o.flow_hit      <= 1'b0;
          out_o.chosen_count  <= '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/least_conn_balancer_with_affinity_top.sv =====
// ----------------------------------------------------------------------------
// least_conn_balancer_with_affinity_top
// Least-connections balancer with client affinity through a flow ring.
// ----------------------------------------------------------------------------
//   channel  dir  handshake    carries
//   in_i     in   valid/ready  packet header or connection-end item
//   out_o    out  valid/ready  one forwarding decision per item
//   cfg_*    in   write enable base address, server count, service port
//
// Connection end and inside packets pass through take and then finish. Outside
// packets walk the flow ring one entry a cycle, newest first, until a hit or
// until every filled entry has been compared. A miss then scans the servers in
// use one a cycle and finishes in the miss state.
// Reset clears counts and ring fill; no clearing pass is needed.
// A held result stalls only the finish step; the next item is taken meanwhile.
module least_conn_balancer_with_affinity_top #(
  parameter int MAX_SERVERS  = 16,
  parameter int FLOW_ENTRIES = 64,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  lcb_in_if.sink      in_i,
  lcb_out_if.source   out_o
);

  lcb_pkg::cmd_t cmd;
  lcb_pkg::sts_t sts;

  lcb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  lcb_dp #(
    .MAX_SERVERS  (MAX_SERVERS),
    .FLOW_ENTRIES (FLOW_ENTRIES),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_i        (in_i),
    .out_o       (out_o)
  );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the least-connections balancer: drives headers and
// connection-end items, predicts each forwarding decision and compares.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic        operation;
    logic        from_outside;
    logic        is_tcp;
    logic [31:0] client_ip;
    logic [15:0] client_port;
    logic [15:0] dest_port;
    logic [3:0]  end_server;
  } hdr_t;

  typedef struct packed {
    logic        forwarded;
    logic [3:0]  chosen_server;
    logic [31:0] server_addr;
    logic [15:0] new_dest_port;
    logic        flow_hit;
    logic [15:0] chosen_count;
  } decision_t;

  localparam int NSRV = 16;
  localparam int NFLOW = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = lcb_pkg::CFG_BASE_ADDR;
  logic [31:0] cfg_wdata_i = '0;

  lcb_in_if  in_ch ();
  lcb_out_if out_ch ();

  least_conn_balancer_with_affinity_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // balancer shadow state
  logic [31:0] base_addr_q = lcb_pkg::RST_BASE_ADDR;
  logic [4:0]  srv_count_q = lcb_pkg::RST_SRV_COUNT;
  logic [15:0] svc_port_q  = lcb_pkg::RST_SVC_PORT;
  logic [15:0] conns [NSRV];
  logic [31:0] ring_addr [NFLOW];
  logic [15:0] ring_port [NFLOW];
  logic [3:0]  ring_srv [NFLOW];
  logic        ring_vld [NFLOW];
  logic [5:0]  ring_wp;

  hdr_t      pending_hdrs[$];
  decision_t expected_decisions[$];
  int        errors = 0;
  int        n_sent = 0, n_hits = 0, n_misses = 0, n_ends = 0;
  int        src_idle_pct = 21, snk_idle_pct = 55, hold_cycles = 0;

  // client pool so that flows recur
  logic [31:0] pool_ip [8];
  logic [15:0] pool_port [8];

  function automatic decision_t decide(hdr_t h);
    decision_t d;
    int n, best, slot;
    logic found;
    d = '0;
    n = (srv_count_q == 0) ? 1 : (srv_count_q > NSRV ? NSRV : srv_count_q);
    if (h.operation) begin
      d.chosen_server = h.end_server;
      if (h.end_server < n) begin
        if (conns[h.end_server] != 0) conns[h.end_server]--;
        d.chosen_count = conns[h.end_server];
      end
      n_ends++;
    end else if (!h.from_outside) begin
      d.new_dest_port = h.dest_port;
    end else begin
      found = 1'b0;
      slot = 0;
      for (int i = 0; i < NFLOW && !found; i++) begin
        slot = (ring_wp + NFLOW - 1 - i) % NFLOW;
        if (ring_vld[slot] && ring_addr[slot] == h.client_ip
            && ring_port[slot] == h.client_port) found = 1'b1;
      end
      d.forwarded = 1'b1;
      if (found) begin
        d.flow_hit = 1'b1;
        d.chosen_server = ring_srv[slot];
        d.new_dest_port = svc_port_q;
        d.chosen_count = conns[ring_srv[slot]];
        n_hits++;
      end else begin
        best = 0;
        for (int k = 1; k < n; k++) if (conns[k] < conns[best]) best = k;
        if (conns[best] != 16'hFFFF) conns[best]++;
        d.chosen_server = best[3:0];
        d.chosen_count = conns[best];
        d.new_dest_port = h.dest_port;
        if (h.is_tcp) begin
          ring_addr[ring_wp] = h.client_ip;
          ring_port[ring_wp] = h.client_port;
          ring_srv[ring_wp] = best[3:0];
          ring_vld[ring_wp] = 1'b1;
          ring_wp = ring_wp + 6'd1;
        end
        n_misses++;
      end
      d.server_addr = base_addr_q + 32'(d.chosen_server);
    end
    return d;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      {in_ch.operation, in_ch.from_outside, in_ch.is_tcp, in_ch.client_ip,
       in_ch.client_port, in_ch.dest_port, in_ch.end_server} <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        void'(pending_hdrs.pop_front());
        n_sent++;
      end
      if (pending_hdrs.size() > 0 && ($urandom_range(99) >= src_idle_pct ||
          (in_ch.valid && !in_ch.ready))) begin
        in_ch.valid <= 1'b1;
        {in_ch.operation, in_ch.from_outside, in_ch.is_tcp, in_ch.client_ip,
         in_ch.client_port, in_ch.dest_port, in_ch.end_server} <= pending_hdrs[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // predict on acceptance, from the values on the bus
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      expected_decisions.push_back(decide({in_ch.operation, in_ch.from_outside,
        in_ch.is_tcp, in_ch.client_ip, in_ch.client_port, in_ch.dest_port,
        in_ch.end_server}));
  end

  // count down a receiver hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    decision_t exp_d;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_decisions.size() == 0) begin
          $error("decision with none expected");
          errors++;
        end else begin
          exp_d = expected_decisions.pop_front();
          if (out_ch.forwarded !== exp_d.forwarded) begin
            $error("forwarded exp %0d got %0d", exp_d.forwarded, out_ch.forwarded);
            errors++;
          end
          if (out_ch.chosen_server !== exp_d.chosen_server) begin
            $error("chosen_server exp %0d got %0d", exp_d.chosen_server,
                   out_ch.chosen_server);
            errors++;
          end
          if (out_ch.server_addr !== exp_d.server_addr) begin
            $error("server_addr exp %h got %h", exp_d.server_addr, out_ch.server_addr);
            errors++;
          end
          if (out_ch.new_dest_port !== exp_d.new_dest_port) begin
            $error("new_dest_port exp %0d got %0d", exp_d.new_dest_port,
                   out_ch.new_dest_port);
            errors++;
          end
          if (out_ch.flow_hit !== exp_d.flow_hit) begin
            $error("flow_hit exp %0d got %0d", exp_d.flow_hit, out_ch.flow_hit);
            errors++;
          end
          if (out_ch.chosen_count !== exp_d.chosen_count) begin
            $error("chosen_count exp %0d got %0d", exp_d.chosen_count,
                   out_ch.chosen_count);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lcb_pkg::CFG_BASE_ADDR: base_addr_q = val;
      lcb_pkg::CFG_SRV_COUNT: srv_count_q = val[4:0];
      lcb_pkg::CFG_SVC_PORT:  svc_port_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_hdrs.size() > 0 || expected_decisions.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic hdr_t packet(logic outside, logic tcp, int who, logic [15:0] dport);
    hdr_t h;
    h = '0;
    h.from_outside = outside;
    h.is_tcp = tcp;
    h.client_ip = pool_ip[who];
    h.client_port = pool_port[who];
    h.dest_port = dport;
    h.end_server = 4'($urandom_range(15));
    return h;
  endfunction

  task automatic add_random(int cnt);
    hdr_t h;
    int r;
    logic [95:0] raw;
    for (int i = 0; i < cnt; i++) begin
      r = $urandom_range(99);
      h = packet(1'b1, $urandom_range(99) < 80, $urandom_range(7),
                 $urandom_range(1) ? svc_port_q : 16'($urandom));
      if (r < 10) begin
        raw = {$urandom, $urandom, $urandom};
        h = raw[$bits(hdr_t)-1:0];
      end else if (r < 30) begin
        h.operation = 1'b1;
        h.end_server = 4'($urandom_range(15));
      end else if (r < 40) begin
        h.client_ip = $urandom;
        h.client_port = 16'($urandom);
      end
      pending_hdrs.push_back(h);
    end
  endtask

  initial begin
    hdr_t h;
    for (int i = 0; i < NSRV; i++) conns[i] = '0;
    for (int i = 0; i < NFLOW; i++) ring_vld[i] = 1'b0;
    ring_wp = '0;
    for (int i = 0; i < 8; i++) begin
      pool_ip[i] = $urandom;
      pool_port[i] = 16'($urandom);
    end
    pool_ip[0] = '0;  pool_port[0] = '0;
    pool_ip[1] = '1;  pool_port[1] = '1;
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: end on idle server, extremes, miss then hit, non-TCP, inside
    h = '0; h.operation = 1'b1; pending_hdrs.push_back(h);
    h.end_server = 4'hF; pending_hdrs.push_back(h);
    pending_hdrs.push_back(packet(1'b0, 1'b1, 1, 16'hFFFF));
    pending_hdrs.push_back(packet(1'b1, 1'b1, 0, 16'd80));
    pending_hdrs.push_back(packet(1'b1, 1'b1, 1, 16'hFFFF));
    pending_hdrs.push_back(packet(1'b1, 1'b1, 0, 16'd0));
    pending_hdrs.push_back(packet(1'b1, 1'b0, 2, 16'd80));
    pending_hdrs.push_back(packet(1'b1, 1'b0, 2, 16'd80));
    for (int i = 0; i < 12; i++) pending_hdrs.push_back(packet(1'b1, 1'b1, 3, 16'd80));
    h = '0; h.operation = 1'b1; h.end_server = 4'd0; pending_hdrs.push_back(h);
    h.end_server = 4'd10; pending_hdrs.push_back(h);
    drain();

    // sender idles lightly, receiver often, with one long hold-off
    write_reg(lcb_pkg::CFG_SRV_COUNT, 32'd1);
    add_random(60);
    hold_cycles = 400;
    drain();
    write_reg(lcb_pkg::CFG_BASE_ADDR, 32'hFFFF_FFF8);
    write_reg(lcb_pkg::CFG_SRV_COUNT, 32'd16);
    write_reg(lcb_pkg::CFG_SVC_PORT, 32'h0000_FFFF);
    add_random(160);
    drain();

    src_idle_pct = 55; snk_idle_pct = 21;
    write_reg(lcb_pkg::CFG_SRV_COUNT, 32'd0);
    write_reg(lcb_pkg::CFG_BASE_ADDR, 32'h0);
    write_reg(lcb_pkg::CFG_SVC_PORT, 32'd0);
    add_random(120);
    drain();
    write_reg(lcb_pkg::CFG_SRV_COUNT, 32'd31);
    add_random(100);
    drain();

    src_idle_pct = 0; snk_idle_pct = 0;
    write_reg(lcb_pkg::CFG_SRV_COUNT, 32'd5);
    write_reg(lcb_pkg::CFG_BASE_ADDR, $urandom);
    write_reg(lcb_pkg::CFG_SVC_PORT, 32'd443);
    add_random(160);
    drain();

    $display("Ran %0d items: %0d flow hits, %0d misses, %0d connection ends,",
             n_sent, n_hits, n_misses, n_ends);
    $display("over server counts 0 to 31 and base/port extremes.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end
endmodule

// ===== least_conn_balancer_with_affinity_top.f =====
rtl/core/lcb_pkg.sv
rtl/core/lcb_in_if.sv
rtl/core/lcb_out_if.sv
rtl/core/lcb_ctrl.sv
rtl/core/lcb_dp.sv
rtl/core/least_conn_balancer_with_affinity_top.sv
tb/testbench.sv
